// ===== hdl/lsbrq_pkg.sv =====
// Shared constants, codes and control types of the sorted box range query block.
package lsbrq_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACT_W  = 2;
    localparam int LAT_W  = 30;
    localparam int LNG_W  = 31;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 3;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_MATCH = 3'd0;
    localparam logic [STAT_W-1:0] ST_NORTH = 3'd1;
    localparam logic [STAT_W-1:0] ST_SOUTH = 3'd2;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic clear;
        logic append;
        logic full_res;
        logic ld_query;
        logic srch_issue;
        logic srch_cmp;
        logic srch_strict;
        logic lat_first;
        logic lat_end;
        logic emit_north;
        logic emit_south;
        logic scan_init;
        logic scan_step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic srch_open;
        logic north;
        logic south;
        logic scan_done;
    } t_sts;

endpackage

// ===== hdl/lat_sorted_box_range_query.sv =====
// Top level of the latitude sorted table with box range queries.
//
// Clear and append items are taken in the cycle start is seen and leave busy low, so they
// can follow each other every cycle; an append to a full table strobes one table full
// result in the next cycle. A box query holds busy high through the lower bound search,
// the upper bound search, a check of the two bounds and, unless the latitude span lies
// north or south of the table, the scan from first to end. Each binary search probe is
// a read and then a compare on the single read port of the latitude memory, and the
// scan reads one longitude and tag per cycle. Results are strobed on o_valid for one
// cycle each and cannot be held off; the final result of a query shows o_last and
// appears in the cycle busy falls.
module lat_sorted_box_range_query (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [lsbrq_pkg::ACT_W-1:0]  i_action,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_entry_lat,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_entry_lng,
    input  logic        [lsbrq_pkg::TAG_W-1:0]  i_entry_tag,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_box_lat_low,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_box_lat_high,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_box_lng_low,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_box_lng_high,
    input  logic        [lsbrq_pkg::TAG_W-1:0]  i_box_tag,
    output logic                                o_valid,
    output logic        [lsbrq_pkg::STAT_W-1:0] o_status,
    output logic        [lsbrq_pkg::TAG_W-1:0]  o_match_tag,
    output logic        [lsbrq_pkg::TAG_W-1:0]  o_echo_box_tag,
    output logic                                o_last
);
    import lsbrq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    lsbrq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lsbrq_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_entry_lat    (i_entry_lat),
        .i_entry_lng    (i_entry_lng),
        .i_entry_tag    (i_entry_tag),
        .i_box_lat_low  (i_box_lat_low),
        .i_box_lat_high (i_box_lat_high),
        .i_box_lng_low  (i_box_lng_low),
        .i_box_lng_high (i_box_lng_high),
        .i_box_tag      (i_box_tag),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_match_tag    (o_match_tag),
        .o_echo_box_tag (o_echo_box_tag),
        .o_last         (o_last)
    );

endmodule

// ===== hdl/lsbrq_ctrl.sv =====
// Controller state machine: sequences append, clear, both bound searches and the scan.
module lsbrq_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lsbrq_pkg::ACT_W-1:0]     i_action,
    input  lsbrq_pkg::t_sts                 i_sts,
    output lsbrq_pkg::t_cmd                 o_cmd,
    output logic                            o_busy
);
    import lsbrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LB,
        S_LB_CMP,
        S_UB,
        S_UB_CMP,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        ACT_APPEND: begin
                            if (i_sts.full) begin
                                o_cmd.full_res = 1'b1;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            o_cmd.ld_query = 1'b1;
                            n_state        = S_LB;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LB: begin
                if (i_sts.srch_open) begin
                    o_cmd.srch_issue = 1'b1;
                    n_state          = S_LB_CMP;
                end else begin
                    o_cmd.lat_first = 1'b1;
                    n_state         = S_UB;
                end
            end
            S_LB_CMP: begin
                o_cmd.srch_cmp = 1'b1;
                n_state        = S_LB;
            end
            S_UB: begin
                if (i_sts.srch_open) begin
                    o_cmd.srch_issue = 1'b1;
                    n_state          = S_UB_CMP;
                end else begin
                    o_cmd.lat_end = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_UB_CMP: begin
                o_cmd.srch_cmp    = 1'b1;
                o_cmd.srch_strict = 1'b1;
                n_state           = S_UB;
            end
            S_CHECK: begin
                if (i_sts.north) begin
                    o_cmd.emit_north = 1'b1;
                    n_state          = S_IDLE;
                end else if (i_sts.south) begin
                    o_cmd.emit_south = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/lsbrq_dpath.sv =====
// Datapath: entry memories, bound search registers, scan pipeline and result registers.
module lsbrq_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsbrq_pkg::t_cmd                     i_cmd,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_entry_lat,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_entry_lng,
    input  logic        [lsbrq_pkg::TAG_W-1:0]  i_entry_tag,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_box_lat_low,
    input  logic signed [lsbrq_pkg::LAT_W-1:0]  i_box_lat_high,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_box_lng_low,
    input  logic signed [lsbrq_pkg::LNG_W-1:0]  i_box_lng_high,
    input  logic        [lsbrq_pkg::TAG_W-1:0]  i_box_tag,
    output lsbrq_pkg::t_sts                     o_sts,
    output logic                                o_valid,
    output logic        [lsbrq_pkg::STAT_W-1:0] o_status,
    output logic        [lsbrq_pkg::TAG_W-1:0]  o_match_tag,
    output logic        [lsbrq_pkg::TAG_W-1:0]  o_echo_box_tag,
    output logic                                o_last
);
    import lsbrq_pkg::*;

    logic signed [LAT_W-1:0] lat_mem [TABLE_DEPTH];
    logic signed [LNG_W-1:0] lng_mem [TABLE_DEPTH];
    logic        [TAG_W-1:0] tag_mem [TABLE_DEPTH];

    logic        [CNT_W-1:0] r_count;
    logic        [CNT_W-1:0] r_lo;
    logic        [CNT_W-1:0] r_hi;
    logic        [CNT_W-1:0] r_first;
    logic        [CNT_W-1:0] r_end;
    logic        [CNT_W-1:0] r_idx;
    logic signed [LAT_W-1:0] r_lat_lo;
    logic signed [LAT_W-1:0] r_lat_hi;
    logic signed [LNG_W-1:0] r_lng_lo;
    logic signed [LNG_W-1:0] r_lng_hi;
    logic        [TAG_W-1:0] r_btag;
    logic signed [LAT_W-1:0] r_rd_lat;
    logic signed [LNG_W-1:0] r_rd_lng;
    logic        [TAG_W-1:0] r_rd_tag;
    logic                    r_chk_vld;
    logic                    r_pend;
    logic        [TAG_W-1:0] r_pend_tag;

    logic                    r_out_vld;
    logic        [STAT_W-1:0] r_out_status;
    logic        [TAG_W-1:0] r_out_tag;
    logic        [TAG_W-1:0] r_out_btag;
    logic                    r_out_last;

    logic                    n_out_vld;
    logic        [STAT_W-1:0] n_out_status;
    logic        [TAG_W-1:0] n_out_tag;
    logic        [TAG_W-1:0] n_out_btag;
    logic                    n_out_last;

    logic        [CNT_W:0]   mid_sum;
    logic        [CNT_W-1:0] mid;
    logic signed [LAT_W-1:0] key;
    logic                    go_right;
    logic                    scan_hit;
    logic                    scan_more;

    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[CNT_W:1];
    assign key       = i_cmd.srch_strict ? r_lat_hi : r_lat_lo;
    assign go_right  = i_cmd.srch_strict ? (r_rd_lat <= key) : (r_rd_lat < key);
    assign scan_hit  = r_chk_vld && !((r_rd_lng < r_lng_lo) || (r_rd_lng > r_lng_hi));
    assign scan_more = (r_idx < r_end);

    assign o_sts.full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign o_sts.srch_open = (r_lo < r_hi);
    assign o_sts.north     = (r_first >= r_count);
    assign o_sts.south     = (r_end == '0);
    assign o_sts.scan_done = !scan_more && !r_chk_vld;

    // entry memories, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            lat_mem[r_count[IDX_W-1:0]] <= i_entry_lat;
            lng_mem[r_count[IDX_W-1:0]] <= i_entry_lng;
            tag_mem[r_count[IDX_W-1:0]] <= i_entry_tag;
        end
        if (i_cmd.srch_issue) begin
            r_rd_lat <= lat_mem[mid[IDX_W-1:0]];
        end
        if (i_cmd.scan_step && scan_more) begin
            r_rd_lng <= lng_mem[r_idx[IDX_W-1:0]];
            r_rd_tag <= tag_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_out_vld    = 1'b0;
        n_out_status = ST_MATCH;
        n_out_tag    = '0;
        n_out_btag   = r_btag;
        n_out_last   = 1'b1;
        if (i_cmd.full_res) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_FULL;
            n_out_btag   = '0;
        end else if (i_cmd.emit_north) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_NORTH;
        end else if (i_cmd.emit_south) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_SOUTH;
        end else if (i_cmd.scan_step && scan_hit && r_pend) begin
            n_out_vld  = 1'b1;
            n_out_tag  = r_pend_tag;
            n_out_last = 1'b0;
        end else if (i_cmd.fin) begin
            n_out_vld = 1'b1;
            if (r_pend) begin
                n_out_tag = r_pend_tag;
            end else begin
                n_out_status = ST_NONE;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.scan_init) begin
                r_chk_vld <= 1'b0;
                r_pend    <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_vld <= scan_more;
                if (scan_hit) begin
                    r_pend <= 1'b1;
                end
            end else if (i_cmd.fin) begin
                r_pend <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_status   <= n_out_status;
        r_out_tag      <= n_out_tag;
        r_out_btag     <= n_out_btag;
        r_out_last     <= n_out_last;
        if (i_cmd.ld_query) begin
            r_lat_lo <= i_box_lat_low;
            r_lat_hi <= i_box_lat_high;
            r_lng_lo <= i_box_lng_low;
            r_lng_hi <= i_box_lng_high;
            r_btag   <= i_box_tag;
        end
        if (i_cmd.ld_query || i_cmd.lat_first) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.srch_cmp) begin
            if (go_right) begin
                r_lo <= mid + CNT_W'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.lat_first) begin
            r_first <= r_lo;
        end
        if (i_cmd.lat_end) begin
            r_end <= r_lo;
        end
        if (i_cmd.scan_init) begin
            r_idx <= r_first;
        end else if (i_cmd.scan_step && scan_more) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.scan_step && scan_hit) begin
            r_pend_tag <= r_rd_tag;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_status;
    assign o_match_tag    = r_out_tag;
    assign o_echo_box_tag = r_out_btag;
    assign o_last         = r_out_last;

endmodule

// ===== hdl/lsbrq_chk.sv =====
// Port level checker for the box range query block and its bind.
module lsbrq_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_valid,
    input logic        [lsbrq_pkg::STAT_W-1:0] o_status,
    input logic        [lsbrq_pkg::TAG_W-1:0]  o_match_tag,
    input logic        [lsbrq_pkg::TAG_W-1:0]  o_echo_box_tag,
    input logic                                o_last
);
    import lsbrq_pkg::*;

    a_flag_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_MATCH)) |-> (o_last && (o_match_tag == '0)))
        else $error("flag result without last or with a tag");

    a_full_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_echo_box_tag == '0))
        else $error("table full result carries a box tag");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("result run not closed while idle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result without a pending item");

endmodule

bind lat_sorted_box_range_query lsbrq_chk u_chk (.*);

// ===== bench/lat_sorted_box_range_query_tb.sv =====
// Self-checking testbench for the sorted latitude table with box range queries.
module lat_sorted_box_range_query_tb;
    import lsbrq_pkg::*;

    localparam int LAT_MAX    = 377487360;
    localparam int LNG_MAX    = 754974720;
    localparam int RAND_ITEMS = 130;
    localparam int SETTLE_CYC = 120;
    localparam int LIMIT      = 500000;
    localparam int FILL_STEP  = 11000000;

    localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;

    localparam logic [1:0] CHK_MODEL = 2'd0;
    localparam logic [1:0] CHK_NONE  = 2'd1;
    localparam logic [1:0] CHK_ONE   = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [LAT_W-1:0] e_lat;
        logic [LNG_W-1:0] e_lng;
        logic [TAG_W-1:0] e_tag;
        logic [LAT_W-1:0] b_lat_lo;
        logic [LAT_W-1:0] b_lat_hi;
        logic [LNG_W-1:0] b_lng_lo;
        logic [LNG_W-1:0] b_lng_hi;
        logic [TAG_W-1:0] b_tag;
    } op_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  mtag;
        logic [TAG_W-1:0]  echo;
        logic              last;
    } res_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        chk;
        logic [STAT_W-1:0] st;
        logic [TAG_W-1:0]  echo;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic        [ACT_W-1:0]   action = '0;
    logic signed [LAT_W-1:0]   entry_lat = '0;
    logic signed [LNG_W-1:0]   entry_lng = '0;
    logic        [TAG_W-1:0]   entry_tag = '0;
    logic signed [LAT_W-1:0]   box_lat_lo = '0;
    logic signed [LAT_W-1:0]   box_lat_hi = '0;
    logic signed [LNG_W-1:0]   box_lng_lo = '0;
    logic signed [LNG_W-1:0]   box_lng_hi = '0;
    logic        [TAG_W-1:0]   box_tag = '0;
    logic                      o_valid;
    logic        [STAT_W-1:0]  o_status;
    logic        [TAG_W-1:0]   o_match_tag;
    logic        [TAG_W-1:0]   o_echo_box_tag;
    logic                      o_last;

    logic signed [LAT_W-1:0] tab_lat [TABLE_DEPTH];
    logic signed [LNG_W-1:0] tab_lng [TABLE_DEPTH];
    logic        [TAG_W-1:0] tab_tag [TABLE_DEPTH];
    int                      tab_cnt = 0;

    res_t     fresh [$];
    res_t     owed [$];
    dir_row_t dir_tab [$];
    int       built_lat [$];
    int       built_lng [$];
    int       errs = 0;
    int       op_cnt = 0;
    int       burst_left = 0;
    int       cyc = 0;

    lat_sorted_box_range_query DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (action),
        .i_entry_lat    (entry_lat),
        .i_entry_lng    (entry_lng),
        .i_entry_tag    (entry_tag),
        .i_box_lat_low  (box_lat_lo),
        .i_box_lat_high (box_lat_hi),
        .i_box_lng_low  (box_lng_lo),
        .i_box_lng_high (box_lng_hi),
        .i_box_tag      (box_tag),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_match_tag    (o_match_tag),
        .o_echo_box_tag (o_echo_box_tag),
        .o_last         (o_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, owed.size());
            $display("FAIL lat_sorted_box_range_query");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_t want;
        if (rst_n && o_valid) begin
            if (owed.size() == 0) begin
                $display("%0t unexpected result: status %0d tag %h box %h last %b", $time,
                         o_status, o_match_tag, o_echo_box_tag, o_last);
                errs++;
            end else begin
                want = owed.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t status: expected %0d actual %0d", $time, want.status,
                             o_status);
                    errs++;
                end
                if (o_match_tag !== want.mtag) begin
                    $display("%0t match_tag: expected %h actual %h", $time, want.mtag,
                             o_match_tag);
                    errs++;
                end
                if (o_echo_box_tag !== want.echo) begin
                    $display("%0t echo_box_tag: expected %h actual %h", $time, want.echo,
                             o_echo_box_tag);
                    errs++;
                end
                if (o_last !== want.last) begin
                    $display("%0t last: expected %b actual %b", $time, want.last, o_last);
                    errs++;
                end
            end
        end
    end

    function automatic int lat_bound(logic signed [LAT_W-1:0] key, bit upper);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tab_cnt;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (upper ? (tab_lat[IDX_W'(mid)] <= key) : (tab_lat[IDX_W'(mid)] < key))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic predict_table_op(input op_t op);
        int   first;
        int   stop;
        res_t r;
        fresh.delete();
        case (op.act)
            ACT_CLEAR: tab_cnt = 0;
            ACT_APPEND: begin
                if (tab_cnt >= TABLE_DEPTH) begin
                    r = '{ST_FULL, 16'h0, 16'h0, 1'b1};
                    fresh.push_back(r);
                end else begin
                    tab_lat[IDX_W'(tab_cnt)] = op.e_lat;
                    tab_lng[IDX_W'(tab_cnt)] = op.e_lng;
                    tab_tag[IDX_W'(tab_cnt)] = op.e_tag;
                    tab_cnt++;
                end
            end
            ACT_QUERY: begin
                first = lat_bound(op.b_lat_lo, 1'b0);
                stop  = lat_bound(op.b_lat_hi, 1'b1);
                if (first >= tab_cnt) begin
                    r = '{ST_NORTH, 16'h0, op.b_tag, 1'b1};
                    fresh.push_back(r);
                end else if (stop == 0) begin
                    r = '{ST_SOUTH, 16'h0, op.b_tag, 1'b1};
                    fresh.push_back(r);
                end else begin
                    for (int i = first; i < stop; i++) begin
                        if (tab_lng[IDX_W'(i)] >= $signed(op.b_lng_lo) &&
                            tab_lng[IDX_W'(i)] <= $signed(op.b_lng_hi)) begin
                            r = '{ST_MATCH, tab_tag[IDX_W'(i)], op.b_tag, 1'b0};
                            fresh.push_back(r);
                        end
                    end
                    if (fresh.size() == 0) begin
                        r = '{ST_NONE, 16'h0, op.b_tag, 1'b1};
                        fresh.push_back(r);
                    end else begin
                        fresh[fresh.size()-1].last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_op(input op_t op, input logic [1:0] chk,
                           input logic [STAT_W-1:0] st, input logic [TAG_W-1:0] echo);
        int   gap;
        res_t r;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            repeat (gap) begin
                @(negedge clk);
                start <= 1'b0;
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        start      <= 1'b1;
        action     <= op.act;
        entry_lat  <= op.e_lat;
        entry_lng  <= op.e_lng;
        entry_tag  <= op.e_tag;
        box_lat_lo <= op.b_lat_lo;
        box_lat_hi <= op.b_lat_hi;
        box_lng_lo <= op.b_lng_lo;
        box_lng_hi <= op.b_lng_hi;
        box_tag    <= op.b_tag;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_table_op(op);
        if (chk == CHK_MODEL) begin
            foreach (fresh[i])
                owed.push_back(fresh[i]);
        end else if (chk == CHK_ONE) begin
            r = '{st, 16'h0, echo, 1'b1};
            owed.push_back(r);
        end
        if (op.act != ACT_IDLE)
            op_cnt++;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic int rnd_lat();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? LAT_MAX : -LAT_MAX;
        return int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
    endfunction

    function automatic int rnd_lng();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? LNG_MAX : -LNG_MAX;
        return int'($urandom_range(0, 2 * LNG_MAX)) - LNG_MAX;
    endfunction

    function automatic int lat_edge();
        int v;
        if (built_lat.size() == 0 || $urandom_range(0, 4) == 0) return rnd_lat();
        v = built_lat[$urandom_range(0, built_lat.size() - 1)];
        case ($urandom_range(0, 3))
            0: v = v - 1;
            1: v = v + 1;
            default: ;
        endcase
        if (v > LAT_MAX) v = LAT_MAX;
        if (v < -LAT_MAX) v = -LAT_MAX;
        return v;
    endfunction

    function automatic int lng_edge();
        int v;
        if (built_lng.size() == 0 || $urandom_range(0, 4) == 0) return rnd_lng();
        v = built_lng[$urandom_range(0, built_lng.size() - 1)];
        case ($urandom_range(0, 3))
            0: v = v - 1;
            1: v = v + 1;
            default: ;
        endcase
        if (v > LNG_MAX) v = LNG_MAX;
        if (v < -LNG_MAX) v = -LNG_MAX;
        return v;
    endfunction

    function automatic op_t rnd_op(logic [ACT_W-1:0] act);
        op_t op;
        op.act      = act;
        op.e_lat    = LAT_W'(rnd_lat());
        op.e_lng    = LNG_W'(rnd_lng());
        op.e_tag    = TAG_W'($urandom_range(0, 65535));
        op.b_lat_lo = LAT_W'(rnd_lat());
        op.b_lat_hi = LAT_W'(rnd_lat());
        op.b_lng_lo = LNG_W'(rnd_lng());
        op.b_lng_hi = LNG_W'(rnd_lng());
        op.b_tag    = TAG_W'($urandom_range(0, 65535));
        return op;
    endfunction

    function automatic op_t mk_app(int lat, int lng, logic [TAG_W-1:0] tag);
        op_t op;
        op       = '0;
        op.act   = ACT_APPEND;
        op.e_lat = LAT_W'(lat);
        op.e_lng = LNG_W'(lng);
        op.e_tag = tag;
        return op;
    endfunction

    function automatic op_t mk_qry(int lat_lo, int lat_hi, int lng_lo, int lng_hi,
                                   logic [TAG_W-1:0] tag);
        op_t op;
        op          = '0;
        op.act      = ACT_QUERY;
        op.b_lat_lo = LAT_W'(lat_lo);
        op.b_lat_hi = LAT_W'(lat_hi);
        op.b_lng_lo = LNG_W'(lng_lo);
        op.b_lng_hi = LNG_W'(lng_hi);
        op.b_tag    = tag;
        return op;
    endfunction

    function automatic dir_row_t row(op_t op, logic [1:0] chk, logic [STAT_W-1:0] st,
                                     logic [TAG_W-1:0] echo);
        dir_row_t d;
        d.op   = op;
        d.chk  = chk;
        d.st   = st;
        d.echo = echo;
        return d;
    endfunction

    initial begin
        op_t op;
        op_t clr;
        op_t ign;
        int  n;
        int  k;
        int  v;
        int  phase;
        int  lo;
        int  hi;
        int  sorted_lat [$];

        clr = '0;
        clr.act = ACT_CLEAR;
        ign = '0;
        ign.act = ACT_IDLE;

        dir_tab.push_back(row(mk_qry(-LAT_MAX, LAT_MAX, -LNG_MAX, LNG_MAX, 16'hFFFF),
                              CHK_ONE, ST_NORTH, 16'hFFFF));
        dir_tab.push_back(row(ign, CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(4, 0, 16'h0001), CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(0, 3, -LNG_MAX, LNG_MAX, 16'h1234),
                              CHK_ONE, ST_SOUTH, 16'h1234));
        dir_tab.push_back(row(mk_qry(5, LAT_MAX, -LNG_MAX, LNG_MAX, 16'h0000),
                              CHK_ONE, ST_NORTH, 16'h0000));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, 4, 0, 0, 16'h0007), CHK_MODEL, ST_MATCH,
                              16'h0));
        dir_tab.push_back(row(clr, CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(-LAT_MAX, -LNG_MAX, 16'hFFFF), CHK_NONE, ST_MATCH,
                              16'h0));
        dir_tab.push_back(row(mk_app(0, 0, 16'h0001), CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(0, LNG_MAX, 16'h8000), CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(0, -1, 16'h00AA), CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(LAT_MAX, LNG_MAX, 16'h5555), CHK_NONE, ST_MATCH,
                              16'h0));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, LAT_MAX, -LNG_MAX, LNG_MAX, 16'hA5A5),
                              CHK_MODEL, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(0, 0, -LNG_MAX, LNG_MAX, 16'h0101), CHK_MODEL,
                              ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(0, 0, 1, LNG_MAX, 16'h0202), CHK_MODEL, ST_MATCH,
                              16'h0));
        dir_tab.push_back(row(mk_qry(1, 0, -LNG_MAX, LNG_MAX, 16'h00F0),
                              CHK_ONE, ST_NONE, 16'h00F0));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, LAT_MAX, 1, -1, 16'h0F00),
                              CHK_ONE, ST_NONE, 16'h0F00));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, -LAT_MAX, -LNG_MAX, -LNG_MAX, 16'h0002),
                              CHK_MODEL, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_app(-5, 0, 16'h0BAD), CHK_MODEL, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, LAT_MAX, -LNG_MAX, LNG_MAX, 16'h3C3C),
                              CHK_MODEL, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(-4, 0, -LNG_MAX, LNG_MAX, 16'h4B4B), CHK_MODEL,
                              ST_MATCH, 16'h0));
        dir_tab.push_back(row(clr, CHK_NONE, ST_MATCH, 16'h0));
        dir_tab.push_back(row(mk_qry(-LAT_MAX, LAT_MAX, -LNG_MAX, LNG_MAX, 16'h7E7E),
                              CHK_ONE, ST_NORTH, 16'h7E7E));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_op(dir_tab[i].op, dir_tab[i].chk, dir_tab[i].st, dir_tab[i].echo);

        // fill the table with latitude pairs, then overflow it
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_op(mk_app(-LAT_MAX + (i / 2) * FILL_STEP, rnd_lng(), TAG_W'(i)), CHK_MODEL,
                    ST_MATCH, 16'h0);
        send_op(mk_app(LAT_MAX, 0, 16'hFFFF), CHK_ONE, ST_FULL, 16'h0);
        send_op(rnd_op(ACT_APPEND), CHK_ONE, ST_FULL, 16'h0);
        send_op(mk_qry(-LAT_MAX, LAT_MAX, -LNG_MAX, LNG_MAX, 16'hC001), CHK_MODEL,
                ST_MATCH, 16'h0);
        send_op(mk_qry(-LAT_MAX + 10 * FILL_STEP, -LAT_MAX + 10 * FILL_STEP, -LNG_MAX,
                       LNG_MAX, 16'hC002), CHK_MODEL, ST_MATCH, 16'h0);
        settle();

        op_cnt = 0;
        phase = 0;
        while (op_cnt < RAND_ITEMS) begin
            phase++;
            if (phase % 6 == 3)
                settle();
            send_op(rnd_op(ACT_CLEAR), CHK_MODEL, ST_MATCH, 16'h0);
            built_lat.delete();
            built_lng.delete();
            sorted_lat.delete();
            n = ($urandom_range(0, 11) == 0) ? TABLE_DEPTH + $urandom_range(1, 2)
                                             : $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                    v = sorted_lat[$urandom_range(0, sorted_lat.size() - 1)];
                else
                    v = rnd_lat();
                k = 0;
                while (k < sorted_lat.size() && sorted_lat[k] <= v)
                    k++;
                sorted_lat.insert(k, v);
            end
            for (int i = 0; i < n; i++) begin
                op = rnd_op(ACT_APPEND);
                op.e_lat = LAT_W'(sorted_lat[i]);
                built_lat.push_back(sorted_lat[i]);
                built_lng.push_back(int'($signed(op.e_lng)));
                send_op(op, CHK_MODEL, ST_MATCH, 16'h0);
            end
            if ($urandom_range(0, 7) == 0) begin
                op = rnd_op(ACT_APPEND);
                built_lat.push_back(int'($signed(op.e_lat)));
                built_lng.push_back(int'($signed(op.e_lng)));
                send_op(op, CHK_MODEL, ST_MATCH, 16'h0);
            end
            if ($urandom_range(0, 7) == 0)
                send_op(rnd_op(ACT_IDLE), CHK_MODEL, ST_MATCH, 16'h0);
            repeat ($urandom_range(2, 8)) begin
                op = rnd_op(ACT_QUERY);
                lo = lat_edge();
                hi = lat_edge();
                if (lo > hi && $urandom_range(0, 5) != 0) begin
                    v = lo;
                    lo = hi;
                    hi = v;
                end
                op.b_lat_lo = LAT_W'(lo);
                op.b_lat_hi = LAT_W'(hi);
                if ($urandom_range(0, 4) == 0) begin
                    op.b_lng_lo = LNG_W'(-LNG_MAX);
                    op.b_lng_hi = LNG_W'(LNG_MAX);
                end else begin
                    lo = lng_edge();
                    hi = lng_edge();
                    if (lo > hi && $urandom_range(0, 5) != 0) begin
                        v = lo;
                        lo = hi;
                        hi = v;
                    end
                    op.b_lng_lo = LNG_W'(lo);
                    op.b_lng_hi = LNG_W'(hi);
                end
                send_op(op, CHK_MODEL, ST_MATCH, 16'h0);
            end
        end

        settle();
        if (errs == 0)
            $display("PASS lat_sorted_box_range_query");
        else
            $display("FAIL lat_sorted_box_range_query");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lsbrq_pkg.sv
hdl/lsbrq_ctrl.sv
hdl/lsbrq_dpath.sv
hdl/lat_sorted_box_range_query.sv
hdl/lsbrq_chk.sv
bench/lat_sorted_box_range_query_tb.sv
